FILE: rtl/apsp_pkg.sv
// shared types and constants of the all-pairs shortest path block
`timescale 1ns / 1ps
`default_nettype none
package apsp_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = NODE_W + 1;
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int MEM_DEPTH = MAX_NODES * MAX_NODES;
   localparam int DIST_W    = 64;
   localparam int EDGE_W    = 32;

   typedef enum logic [1:0] {
      RQ_CLEAR = 2'd0,
      RQ_EDGE  = 2'd1,
      RQ_BUILD = 2'd2,
      RQ_QUERY = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNREACH = 2'd1,
      ST_BROKEN  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WR_CLEAR = 2'd0,
      WR_EDGE  = 2'd1,
      WR_RELAX = 2'd2
   } wsel_type;

   // one matrix entry
   typedef struct packed {
      logic signed [DIST_W-1:0] weight;
      logic                     reach;
      logic                     hop_valid;
      logic [NODE_W-1:0]        hop;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic              wr_en;
      wsel_type          wr_sel;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              cap_legs;
      logic              cap_sum;
      logic              neg_clear;
      logic              neg_check;
      logic              cap_cost;
      logic              out_load;
      status_type        out_status;
      logic [NODE_W-1:0] out_node;
      logic              out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic              rd_reach;
      logic              rd_hop_valid;
      logic [NODE_W-1:0] rd_hop;
      logic              out_free;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/apsp_req_if.sv
// request channel: valid/ready with one request beat
`timescale 1ns / 1ps
`default_nettype none
interface apsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [4:0]  src_node;
   logic [4:0]  dst_node;
   logic [31:0] edge_cost;

   modport source (output valid, req_type, src_node, dst_node, edge_cost, input ready);
   modport sink   (input valid, req_type, src_node, dst_node, edge_cost, output ready);
endinterface
`default_nettype wire

FILE: rtl/apsp_rsp_if.sv
// response channel: valid/ready with one result beat
`timescale 1ns / 1ps
`default_nettype none
interface apsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] path_cost;
   logic        reachable;
   logic        negative_cycle;
   logic [4:0]  path_node;
   logic        last;

   modport source (output valid, status, path_cost, reachable, negative_cycle, path_node,
                   last, input ready);
   modport sink   (input valid, status, path_cost, reachable, negative_cycle, path_node,
                   last, output ready);
endinterface
`default_nettype wire

FILE: rtl/apsp_dpath.sv
// matrix memory, relaxation arithmetic, negative-cycle flag and result register
`timescale 1ns / 1ps
`default_nettype none
module apsp_dpath
   import apsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [NODE_W-1:0] edge_dst,
   input  wire logic [EDGE_W-1:0] edge_cost,
   output stat_type               stat,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [DIST_W-1:0]      rsp_path_cost,
   output logic                   rsp_reachable,
   output logic                   rsp_negative_cycle,
   output logic [NODE_W-1:0]      rsp_path_node,
   output logic                   rsp_last
);

   entry_type dist_mem [MEM_DEPTH];
   entry_type rd_a_ff, rd_b_ff;
   entry_type leg_ik_ff;
   logic signed [DIST_W-1:0] leg_kj_ff;
   logic leg_kj_reach_ff;
   logic signed [DIST_W-1:0] sum_ff, sum_in;
   logic signed [DIST_W-1:0] ij_dist_ff;
   logic ij_reach_ff, legs_ok_ff;
   logic neg_ff, neg_in;
   logic signed [DIST_W-1:0] cost_ff;
   logic upd;
   logic mem_we;
   entry_type wr_data;
   logic [DIST_W-1:0] raw_sum;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff;
   logic [DIST_W-1:0] out_cost_ff;
   logic              out_reach_ff, out_neg_ff, out_last_ff;
   logic [NODE_W-1:0] out_node_ff;

   // relaxation: update when legs reach and target unreachable or longer
   assign upd = legs_ok_ff && (!ij_reach_ff || (sum_ff < ij_dist_ff));

   // write data select
   always_comb begin
      wr_data = '0;
      unique case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_data.reach = (cmd.wr_addr[ADDR_W-1:NODE_W] == cmd.wr_addr[NODE_W-1:0]);
         end
         WR_EDGE: begin
            wr_data.weight    = DIST_W'(signed'(edge_cost));
            wr_data.reach     = 1'b1;
            wr_data.hop_valid = 1'b1;
            wr_data.hop       = edge_dst;
         end
         WR_RELAX: begin
            wr_data.weight    = sum_ff;
            wr_data.reach     = 1'b1;
            wr_data.hop_valid = leg_ik_ff.hop_valid;
            wr_data.hop       = leg_ik_ff.hop;
         end
         default: wr_data = '0;
      endcase
   end

   assign mem_we = cmd.wr_en && ((cmd.wr_sel != WR_RELAX) || upd);

   // matrix memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dist_mem[cmd.wr_addr] <= wr_data;
      end
      rd_a_ff <= dist_mem[cmd.rd_addr_a];
      rd_b_ff <= dist_mem[cmd.rd_addr_b];
   end

   // saturating sum of the two legs
   always_comb begin
      raw_sum = leg_ik_ff.weight + leg_kj_ff;
      sum_in  = signed'(raw_sum);
      if ((leg_ik_ff.weight[DIST_W-1] == leg_kj_ff[DIST_W-1]) &&
          (raw_sum[DIST_W-1] != leg_ik_ff.weight[DIST_W-1])) begin
         sum_in = leg_ik_ff.weight[DIST_W-1] ? {1'b1, {(DIST_W-1){1'b0}}}
                                             : {1'b0, {(DIST_W-1){1'b1}}};
      end
   end

   // operand capture for relaxation and query cost
   always_ff @(posedge clock) begin
      if (cmd.cap_legs) begin
         leg_ik_ff       <= rd_a_ff;
         leg_kj_ff       <= rd_b_ff.weight;
         leg_kj_reach_ff <= rd_b_ff.reach;
      end
      if (cmd.cap_sum) begin
         sum_ff      <= sum_in;
         legs_ok_ff  <= leg_ik_ff.reach && leg_kj_reach_ff;
         ij_dist_ff  <= rd_a_ff.weight;
         ij_reach_ff <= rd_a_ff.reach;
      end
      if (cmd.cap_cost) begin
         cost_ff <= rd_a_ff.weight;
      end
   end

   // negative-cycle flag
   always_comb begin
      neg_in = neg_ff;
      if (cmd.neg_clear) begin
         neg_in = 1'b0;
      end else if (cmd.neg_check && rd_a_ff.weight[DIST_W-1]) begin
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff <= 1'b0;
      end else begin
         neg_ff <= neg_in;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= cmd.out_status;
         out_cost_ff   <= (cmd.out_status == ST_UNREACH) ? '0 : cost_ff;
         out_reach_ff  <= (cmd.out_status != ST_UNREACH);
         out_neg_ff    <= neg_ff;
         out_node_ff   <= cmd.out_node;
         out_last_ff   <= cmd.out_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_path_cost      = out_cost_ff;
   assign rsp_reachable      = out_reach_ff;
   assign rsp_negative_cycle = out_neg_ff;
   assign rsp_path_node      = out_node_ff;
   assign rsp_last           = out_last_ff;

   // status back to the controller
   assign stat.rd_reach     = rd_a_ff.reach;
   assign stat.rd_hop_valid = rd_a_ff.hop_valid;
   assign stat.rd_hop       = rd_a_ff.hop;
   assign stat.out_free     = !out_valid_ff || rsp_ready;

endmodule
`default_nettype wire

FILE: rtl/apsp_ctrl.sv
// sequencer for clearing, edge loads, build sweep, diagonal check and path walk
`timescale 1ns / 1ps
`default_nettype none
module apsp_ctrl
   import apsp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [NODE_W-1:0]  req_src,
   input  wire logic [NODE_W-1:0]  req_dst,
   output cmd_type                 cmd,
   input  wire stat_type           stat
);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_RX_A   = 12'b000000000100,
      S_RX_B   = 12'b000000001000,
      S_RX_C   = 12'b000000010000,
      S_RX_D   = 12'b000000100000,
      S_DG_A   = 12'b000001000000,
      S_DG_B   = 12'b000010000000,
      S_Q_RD   = 12'b000100000000,
      S_W_TEST = 12'b001000000000,
      S_W_CHK  = 12'b010000000000,
      S_EMIT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] ncount_ff;
   logic [COUNT_W-1:0] nodes;
   logic [NODE_W-1:0]  nm1;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [NODE_W-1:0]  at_ff, at_in, qdst_ff, qdst_in, idx_ff, idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               qbad_ff, qbad_in;
   status_type         emit_ff, emit_in;
   logic [NODE_W-1:0]  path_ff [MAX_NODES];
   logic               path_we;
   logic [NODE_W-1:0]  path_wdata;
   logic               accept;
   logic               src_ok, dst_ok;

   // node count register and its clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= COUNT_W'(MAX_NODES);
      end else if (csr_wr_en) begin
         ncount_ff <= csr_wr_data;
      end
   end

   always_comb begin
      nodes = ncount_ff;
      if (ncount_ff == '0) begin
         nodes = COUNT_W'(1);
      end else if (ncount_ff > COUNT_W'(MAX_NODES)) begin
         nodes = COUNT_W'(MAX_NODES);
      end
   end

   assign nm1       = NODE_W'(nodes - COUNT_W'(1));
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign src_ok    = {1'b0, req_src} < nodes;
   assign dst_ok    = {1'b0, req_dst} < nodes;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      at_in      = at_ff;
      qdst_in    = qdst_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      qbad_in    = qbad_ff;
      emit_in    = emit_ff;
      path_we    = 1'b0;
      path_wdata = at_ff;
      cmd        = '0;
      cmd.wr_sel     = WR_CLEAR;
      cmd.out_status = ST_OK;
      cmd.rd_addr_a  = {i_ff, k_ff};
      cmd.rd_addr_b  = {k_ff, j_ff};

      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_CLEAR;
            cmd.wr_addr = clr_ff;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.rd_addr_a = {req_src, req_dst};
            if (accept) begin
               unique case (req_kind_type'(req_kind))
                  RQ_CLEAR: begin
                     cmd.neg_clear = 1'b1;
                     clr_in        = '0;
                     state_in      = S_CLEAR;
                  end
                  RQ_EDGE: begin
                     cmd.wr_en   = src_ok && dst_ok;
                     cmd.wr_sel  = WR_EDGE;
                     cmd.wr_addr = {req_src, req_dst};
                  end
                  RQ_BUILD: begin
                     k_in     = '0;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = S_RX_A;
                  end
                  RQ_QUERY: begin
                     at_in    = req_src;
                     qdst_in  = req_dst;
                     qbad_in  = !(src_ok && dst_ok);
                     state_in = S_Q_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // relaxation of one (k, i, j) triple
         S_RX_A: begin
            state_in = S_RX_B;
         end
         S_RX_B: begin
            cmd.cap_legs  = 1'b1;
            cmd.rd_addr_a = {i_ff, j_ff};
            state_in      = S_RX_C;
         end
         S_RX_C: begin
            cmd.cap_sum = 1'b1;
            state_in    = S_RX_D;
         end
         S_RX_D: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_RELAX;
            cmd.wr_addr = {i_ff, j_ff};
            state_in    = S_RX_A;
            if (j_ff == nm1) begin
               j_in = '0;
               if (i_ff == nm1) begin
                  i_in = '0;
                  if (k_ff == nm1) begin
                     state_in = S_DG_A;
                  end else begin
                     k_in = k_ff + NODE_W'(1);
                  end
               end else begin
                  i_in = i_ff + NODE_W'(1);
               end
            end else begin
               j_in = j_ff + NODE_W'(1);
            end
         end
         // diagonal sign check
         S_DG_A: begin
            cmd.rd_addr_a = {i_ff, i_ff};
            state_in      = S_DG_B;
         end
         S_DG_B: begin
            cmd.neg_check = 1'b1;
            if (i_ff == nm1) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + NODE_W'(1);
               state_in = S_DG_A;
            end
         end
         // query: pair lookup
         S_Q_RD: begin
            cmd.cap_cost = 1'b1;
            cnt_in       = '0;
            if (qbad_ff || !stat.rd_reach) begin
               emit_in  = ST_UNREACH;
               state_in = S_EMIT;
            end else begin
               state_in = S_W_TEST;
            end
         end
         // walk the next hops toward the end node
         S_W_TEST: begin
            cmd.rd_addr_a = {at_ff, qdst_ff};
            if (cnt_ff == COUNT_W'(MAX_NODES)) begin
               emit_in  = ST_BROKEN;
               state_in = S_EMIT;
            end else begin
               path_we = 1'b1;
               cnt_in  = cnt_ff + COUNT_W'(1);
               if (at_ff == qdst_ff) begin
                  idx_in   = '0;
                  emit_in  = ST_OK;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_W_CHK;
               end
            end
         end
         S_W_CHK: begin
            if (stat.rd_hop_valid && ({1'b0, stat.rd_hop} < nodes)) begin
               at_in    = stat.rd_hop;
               state_in = S_W_TEST;
            end else begin
               emit_in  = ST_BROKEN;
               state_in = S_EMIT;
            end
         end
         // result beats
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = emit_ff;
               if (emit_ff == ST_OK) begin
                  cmd.out_node = path_ff[idx_ff];
                  cmd.out_last = ({1'b0, idx_ff} + COUNT_W'(1)) == cnt_ff;
                  idx_in       = idx_ff + NODE_W'(1);
                  if (cmd.out_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.out_last = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      at_ff   <= at_in;
      qdst_ff <= qdst_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      qbad_ff <= qbad_in;
      emit_ff <= emit_in;
      if (path_we) begin
         path_ff[cnt_ff[NODE_W-1:0]] <= path_wdata;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/all_pairs_shortest_path.sv
// top level of the all-pairs shortest path block
`timescale 1ns / 1ps
`default_nettype none
// All-pairs shortest paths (Floyd-Warshall) over up to 32 nodes held in a
// 1024-entry matrix memory with 64-bit saturating distances and next hops.
// After reset, and after every clear request, the block sweeps the memory
// one entry a cycle and holds req ready low meanwhile. An edge request is
// written as it is accepted. A build relaxes every (k, i, j) triple of the
// nodes in use: each relaxation reads both legs, reads the target, then
// writes it back; a diagonal sign check follows. A query does the pair
// lookup and walks the next hops to the end node, then gives one result
// beat per cycle as the response side takes them. Requests are handled one
// at a time; the last result beat waits in an output register while the
// next request is taken. node_count is to be written through csr_wr_en and
// csr_wr_data only while the block is idle; the block has no check for it.
module all_pairs_shortest_path
   import apsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data,
   apsp_req_if.sink        req_bus,
   apsp_rsp_if.source      rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   apsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_kind    (req_bus.req_type),
      .req_src     (req_bus.src_node),
      .req_dst     (req_bus.dst_node),
      .cmd         (cmd),
      .stat        (stat)
   );

   apsp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .edge_dst           (req_bus.dst_node),
      .edge_cost          (req_bus.edge_cost),
      .stat               (stat),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_status         (rsp_bus.status),
      .rsp_path_cost      (rsp_bus.path_cost),
      .rsp_reachable      (rsp_bus.reachable),
      .rsp_negative_cycle (rsp_bus.negative_cycle),
      .rsp_path_node      (rsp_bus.path_node),
      .rsp_last           (rsp_bus.last)
   );

endmodule
`default_nettype wire

FILE: rtl/apsp_checker.sv
// port-level checker for the all-pairs shortest path block and its bind
`timescale 1ns / 1ps
`default_nettype none
module apsp_checker
   import apsp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [63:0] rsp_path_cost,
   input wire logic        rsp_reachable,
   input wire logic        rsp_last
);

   // a pending beat stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before taken");

   // memory sweep follows reset
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during reset sweep");

   // a clear starts a sweep
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == RQ_CLEAR) |=> !req_ready)
      else $error("request taken right after clear");

   // error beats stand alone
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
      else $error("error beat without last");

   // unreachable beats carry no cost and are not reachable
   a_unreach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNREACH) |-> !rsp_reachable && (rsp_path_cost == '0))
      else $error("unreachable beat with cost or reach");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_type      (req_bus.req_type),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_path_cost (rsp_bus.path_cost),
   .rsp_reachable (rsp_bus.reachable),
   .rsp_last      (rsp_bus.last)
);
`default_nettype wire

FILE: tb/all_pairs_shortest_path_test.sv
// testbench of the all-pairs shortest path block: directed and random requests checked beat by beat
`timescale 1ns / 1ps
`default_nettype none
module all_pairs_shortest_path_test;
   import apsp_pkg::*;

   localparam longint DIST_MIN = 64'sh8000_0000_0000_0000;
   localparam longint DIST_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam int     PATH_CAP = 32;

   typedef struct {
      status_type  status;
      longint      cost;
      bit          reach;
      bit          neg;
      bit [4:0]    node;
      bit          last;
   } path_beat_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [5:0] csr_wr_data;

   apsp_req_if req_bus ();
   apsp_rsp_if rsp_bus ();

   all_pairs_shortest_path dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // shadow copy of the matrix and the register
   longint     dist_shadow [MAX_NODES][MAX_NODES];
   bit         reach_shadow [MAX_NODES][MAX_NODES];
   bit [4:0]   hop_shadow [MAX_NODES][MAX_NODES];
   bit         hop_ok_shadow [MAX_NODES][MAX_NODES];
   bit         neg_shadow;
   bit [5:0]   node_count_shadow;

   path_beat_t pending_beats[$];
   int         error_count;
   int         beats_seen;
   int         requests_sent;
   int         queries_sent;
   int         builds_sent;
   bit         no_gaps;
   int         stall_left;

   always #2 clock = ~clock;

   function automatic int nodes_in_use();
      if (node_count_shadow == 0) return 1;
      if (node_count_shadow > MAX_NODES) return MAX_NODES;
      return node_count_shadow;
   endfunction

   function automatic void wipe_matrix();
      for (int i = 0; i < MAX_NODES; i++)
         for (int j = 0; j < MAX_NODES; j++) begin
            dist_shadow[i][j] = 0;
            reach_shadow[i][j] = (i == j);
            hop_shadow[i][j] = 0;
            hop_ok_shadow[i][j] = 0;
         end
      neg_shadow = 0;
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (a < 0 && b < 0 && s >= 0) return DIST_MIN;
      if (a >= 0 && b >= 0 && s < 0) return DIST_MAX;
      return s;
   endfunction

   function automatic void relax_all();
      int n;
      longint s;
      n = nodes_in_use();
      for (int k = 0; k < n; k++)
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               if (!reach_shadow[i][k] || !reach_shadow[k][j]) continue;
               s = sat_sum(dist_shadow[i][k], dist_shadow[k][j]);
               if (!reach_shadow[i][j] || s < dist_shadow[i][j]) begin
                  dist_shadow[i][j] = s;
                  reach_shadow[i][j] = 1;
                  hop_shadow[i][j] = hop_shadow[i][k];
                  hop_ok_shadow[i][j] = hop_ok_shadow[i][k];
               end
            end
      for (int i = 0; i < n; i++)
         if (dist_shadow[i][i] < 0) neg_shadow = 1;
   endfunction

   function automatic void push_beat(status_type st, longint cost, bit reach,
                                     bit [4:0] node, bit last);
      path_beat_t b;
      b.status = st;
      b.cost = cost;
      b.reach = reach;
      b.neg = neg_shadow;
      b.node = node;
      b.last = last;
      pending_beats = {pending_beats, b};
   endfunction

   function automatic void walk_path(int s, int d);
      int n;
      int at;
      int cnt;
      bit ok;
      int route [PATH_CAP];
      longint cost;
      n = nodes_in_use();
      if (s >= n || d >= n || !reach_shadow[s][d]) begin
         push_beat(ST_UNREACH, 0, 0, 0, 1);
         return;
      end
      cost = dist_shadow[s][d];
      at = s;
      cnt = 0;
      ok = 1;
      while (at != d) begin
         if (cnt >= PATH_CAP) begin
            ok = 0;
            break;
         end
         route[cnt++] = at;
         if (!hop_ok_shadow[at][d] || hop_shadow[at][d] >= n) begin
            ok = 0;
            break;
         end
         at = hop_shadow[at][d];
      end
      if (ok && cnt >= PATH_CAP) ok = 0;
      if (!ok) begin
         push_beat(ST_BROKEN, cost, 1, 0, 1);
         return;
      end
      route[cnt++] = d;
      for (int k = 0; k < cnt; k++) push_beat(ST_OK, cost, 1, 5'(route[k]), k == cnt - 1);
   endfunction

   // update the shadow for one accepted request
   function automatic void apply_request(req_kind_type kind, int s, int d, logic [31:0] c);
      int n;
      n = nodes_in_use();
      case (kind)
         RQ_CLEAR: wipe_matrix();
         RQ_EDGE: begin
            if (s < n && d < n) begin
               dist_shadow[s][d] = longint'(signed'(c));
               reach_shadow[s][d] = 1;
               hop_shadow[s][d] = 5'(d);
               hop_ok_shadow[s][d] = 1;
            end
         end
         RQ_BUILD: relax_all();
         default: walk_path(s, d);
      endcase
   endfunction

   // send one request beat; valid stays high when the next follows at once
   task automatic send_request(req_kind_type kind, bit [4:0] s, bit [4:0] d, logic [31:0] c);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.src_node <= s;
      req_bus.dst_node <= d;
      req_bus.edge_cost <= c;
      do @(posedge clock); while (!req_bus.ready);
      apply_request(kind, s, d, c);
      requests_sent++;
      if (kind == RQ_QUERY) queries_sent++;
      if (kind == RQ_BUILD) builds_sent++;
   endtask

   // bring the block to idle: a query drains everything before it
   task automatic settle();
      send_request(RQ_QUERY, 0, 0, 0);
      req_bus.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(bit [5:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_count_shadow = value;
   endtask

   // result beat checker and response stall
   always @(posedge clock) begin
      path_beat_t e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               e = pending_beats.pop_front();
               if (rsp_bus.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.path_cost !== e.cost) begin
                  $error("path_cost: expected %0d, got %0d", e.cost,
                         $signed(rsp_bus.path_cost));
                  error_count++;
               end
               if (rsp_bus.reachable !== e.reach) begin
                  $error("reachable: expected %0d, got %0d", e.reach, rsp_bus.reachable);
                  error_count++;
               end
               if (rsp_bus.negative_cycle !== e.neg) begin
                  $error("negative_cycle: expected %0d, got %0d", e.neg,
                         rsp_bus.negative_cycle);
                  error_count++;
               end
               if (rsp_bus.path_node !== e.node) begin
                  $error("path_node: expected %0d, got %0d", e.node, rsp_bus.path_node);
                  error_count++;
               end
               if (rsp_bus.last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_bus.last);
                  error_count++;
               end
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 18);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // state right after reset, full node count, extreme 32-bit edge costs
   task automatic test_reset_state();
      no_gaps = 0;
      send_request(RQ_QUERY, 0, 0, 0);
      send_request(RQ_QUERY, 31, 31, 0);
      send_request(RQ_QUERY, 0, 31, 0);
      send_request(RQ_EDGE, 0, 31, 32'h7fff_ffff);
      send_request(RQ_EDGE, 31, 30, 32'h7fff_ffff);
      send_request(RQ_EDGE, 0, 31, 32'd5);
      send_request(RQ_EDGE, 30, 30, 32'h8000_0000);
      send_request(RQ_QUERY, 0, 31, 0);
      send_request(RQ_BUILD, 0, 0, 0);
      send_request(RQ_QUERY, 0, 30, 0);
      send_request(RQ_QUERY, 30, 30, 0);
      send_request(RQ_QUERY, 5, 31, 0);
   endtask

   // clear, node count limits, ignored edges and a hop past the node count
   task automatic test_node_limits();
      no_gaps = 1;
      write_node_count(6'd0);
      send_request(RQ_CLEAR, 0, 0, 0);
      send_request(RQ_EDGE, 0, 1, 32'd3);
      send_request(RQ_QUERY, 0, 1, 0);
      write_node_count(6'd63);
      write_node_count(6'd8);
      send_request(RQ_EDGE, 9, 1, 32'd1);
      send_request(RQ_EDGE, 0, 6, 32'd1);
      send_request(RQ_EDGE, 6, 1, 32'd1);
      send_request(RQ_BUILD, 0, 0, 0);
      write_node_count(6'd4);
      send_request(RQ_QUERY, 0, 1, 0);
      send_request(RQ_QUERY, 0, 5, 0);
      write_node_count(6'd33);
      send_request(RQ_QUERY, 0, 1, 0);
   endtask

   function automatic logic [31:0] draw_cost();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return $urandom();
      if (r < 3) return -$urandom_range(1, 4);
      return $urandom_range(0, 20);
   endfunction

   // random graphs: well-formed clear/edges/build/query runs plus noise
   task automatic test_random_graphs();
      int n;
      int r;
      int edges;
      while (requests_sent < 250) begin
         r = $urandom_range(0, 9);
         n = (r == 0) ? 1 : (r == 1) ? 12 : $urandom_range(2, 6);
         no_gaps = ($urandom_range(0, 3) == 0);
         write_node_count(6'(n));
         send_request(RQ_CLEAR, 5'($urandom()), 5'($urandom()), $urandom());
         edges = $urandom_range(n, 3 * n);
         for (int e = 0; e < edges; e++) begin
            if ($urandom_range(0, 9) == 0)
               send_request(req_kind_type'($urandom_range(0, 3)), 5'($urandom()),
                            5'($urandom()), $urandom());
            else
               send_request(RQ_EDGE, 5'($urandom_range(0, n - 1)),
                            5'($urandom_range(0, n - 1)), draw_cost());
         end
         if ($urandom_range(0, 3) != 0) send_request(RQ_BUILD, 0, 0, 0);
         if ($urandom_range(0, 2) == 0)
            send_request(RQ_BUILD, 5'($urandom()), 5'($urandom()), 0);
         for (int q = 0; q < n + 2; q++) begin
            if ($urandom_range(0, 7) == 0)
               send_request(RQ_QUERY, 5'($urandom()), 5'($urandom()), $urandom());
            else
               send_request(RQ_QUERY, 5'($urandom_range(0, n - 1)),
                            5'($urandom_range(0, n - 1)), 0);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 6'd0;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= RQ_CLEAR;
      req_bus.src_node <= 5'd0;
      req_bus.dst_node <= 5'd0;
      req_bus.edge_cost <= 32'd0;
      error_count = 0;
      beats_seen = 0;
      requests_sent = 0;
      queries_sent = 0;
      builds_sent = 0;
      no_gaps = 0;
      node_count_shadow = 6'd32;
      wipe_matrix();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_node_limits();
      test_random_graphs();

      req_bus.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d requests (%0d queries, %0d builds), %0d result beats checked",
               requests_sent, queries_sent, builds_sent, beats_seen);
      if (error_count == 0) begin
         $display("all_pairs_shortest_path_test: done, clean");
      end else begin
         $display("all_pairs_shortest_path_test: done, errors");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20ms;
      $display("timed out");
      $display("all_pairs_shortest_path_test: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
